// File: sv/rv32i_integer_execute_unit_macros.svh
// assertion macros shared by the rv32i integer execute unit
// expects signals named clock and reset in the scope of use
`ifndef RV32I_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RVX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RVX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rvx_pkg.sv
// shared types and constants of the rv32i integer execute unit
// no dependencies
package rvx_pkg;

   localparam int XLEN     = 32;
   localparam int NUM_REGS = 32;
   localparam int REG_IDX  = $clog2(NUM_REGS);
   localparam int CMD_W    = 3;

   localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

   // instruction group carried with each item
   typedef enum logic [CMD_W-1:0] {
      CMD_REG    = 3'd0,
      CMD_IMM    = 3'd1,
      CMD_LUI    = 3'd2,
      CMD_BRANCH = 3'd3,
      CMD_JAL    = 3'd4,
      CMD_JALR   = 3'd5
   } cmd_type;

   // funct3 codes, alu ops
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // funct3 codes, branches
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_JALR = 3'd0;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   typedef struct packed {
      logic [REG_IDX-1:0] dest_reg;
      logic [XLEN-1:0]    dest_value;
      logic               dest_write;
      logic [XLEN-1:0]    next_pc;
      logic               redirected;
      logic               illegal;
   } rsp_type;

endpackage

// File: sv/rvx_req_if.sv
// instruction channel: valid/ready handshake with group and instruction word
// depends on rvx_pkg
interface rvx_req_if;
   import rvx_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [XLEN-1:0]   instruction;

   modport source (output valid, output cmd, output instruction, input ready);
   modport sink   (input valid, input cmd, input instruction, output ready);
endinterface

// File: sv/rvx_rsp_if.sv
// result channel: valid/ready handshake with write-back and pc fields
// depends on rvx_pkg
interface rvx_rsp_if;
   import rvx_pkg::*;

   logic               valid;
   logic               ready;
   logic [REG_IDX-1:0] dest_reg;
   logic [XLEN-1:0]    dest_value;
   logic               dest_write;
   logic [XLEN-1:0]    next_pc;
   logic               redirected;
   logic               illegal;

   modport source (output valid, output dest_reg, output dest_value, output dest_write,
                   output next_pc, output redirected, output illegal, input ready);
   modport sink   (input valid, input dest_reg, input dest_value, input dest_write,
                   input next_pc, input redirected, input illegal, output ready);
endinterface

// File: sv/rv32i_integer_execute_unit.sv
// rv32i integer execute unit: register file memory, pc and single-stage alu
// depends on rvx_pkg, rvx_req_if, rvx_rsp_if and the assertion macros header
//
// usage
//   req_bus carries one instruction item: cmd selects the group (reg-reg, reg-imm,
//   lui, branch, jal, jalr) and instruction is the 32-bit word. rsp_bus returns
//   one result item per instruction, in order: register write-back, next pc,
//   redirect and illegal flags.
//   the register file is a synchronous memory with two read ports read at
//   the accept edge into the execute stage registers; the alu, branch compare
//   and write-back work in the execute stage, and the result then sits in the
//   output register.
//   throughput: one item per cycle while rsp_bus.ready stays high. a result
//   written back in the execute cycle is forwarded to the item read in that
//   same cycle, so dependent instructions may follow back to back.
//   reset (synchronous): pc returns to zero and all registers read as zero at
//   once through per-entry valid bits; no clearing pass is needed.
//   stall: when rsp_bus.ready is low the output register holds its item, the
//   execute stage holds the next one, and req_bus.ready falls only once both
//   are full.
module rv32i_integer_execute_unit (
   input  logic       clock,
   input  logic       reset,
   rvx_req_if.sink    req_bus,
   rvx_rsp_if.source  rsp_bus
);
   import rvx_pkg::*;

   `include "rv32i_integer_execute_unit_macros.svh"

   // register file memory and its entry valid bits
   logic [XLEN-1:0]      rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0]  rf_vld_ff;

   // execute stage
   logic                 s1_valid_ff;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [XLEN-1:0]      s1_instr_ff;
   logic [XLEN-1:0]      rs1_data_ff, rs2_data_ff;
   logic                 rs1_vld_ff, rs2_vld_ff;

   // last write-back, forwarded to the item whose read raced it
   logic                 fwd_valid_ff;
   logic [REG_IDX-1:0]   fwd_addr_ff;
   logic [XLEN-1:0]      fwd_data_ff;

   logic [XLEN-1:0]      pc_ff;

   // output register
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 req_acc, s1_adv;
   logic [REG_IDX-1:0]   req_rs1, req_rs2;

   // write-back port
   logic                 rf_we;
   logic [REG_IDX-1:0]   rf_waddr;
   logic [XLEN-1:0]      rf_wdata;

   // decode fields
   logic [REG_IDX-1:0]   rd, rs1, rs2;
   logic [2:0]           f3;
   logic [6:0]           f7;
   logic [XLEN-1:0]      op_a, op_b;
   logic [XLEN-1:0]      imm_i, imm_b, imm_j, imm_u;
   logic [XLEN-1:0]      seq_pc;
   logic [4:0]           shamt;
   logic [2*XLEN-1:0]    rot_wide;

   logic [XLEN-1:0]      val;
   logic [XLEN-1:0]      npc;
   logic                 wr, redir, ill, take;
   logic                 lt_s, lt_u;

   // handshake: the execute stage moves on when the output register is free
   assign s1_adv  = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_acc = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;

   assign req_rs1 = req_bus.instruction[19:15];
   assign req_rs2 = req_bus.instruction[24:20];

   // memory: read on accept, write from execute stage
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (req_acc) begin
         rs1_data_ff <= rf_mem[req_rs1];
         rs2_data_ff <= rf_mem[req_rs2];
         rs1_vld_ff  <= rf_vld_ff[req_rs1];
         rs2_vld_ff  <= rf_vld_ff[req_rs2];
         s1_cmd_ff   <= req_bus.cmd;
         s1_instr_ff <= req_bus.instruction;
      end
   end

   // decode
   assign rd  = s1_instr_ff[11:7];
   assign rs1 = s1_instr_ff[19:15];
   assign rs2 = s1_instr_ff[24:20];
   assign f3  = s1_instr_ff[14:12];
   assign f7  = s1_instr_ff[31:25];

   // operands: forwarded write first, then memory, entries never written read zero
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == rs1) begin
         op_a = fwd_data_ff;
      end else if (rs1_vld_ff) begin
         op_a = rs1_data_ff;
      end else begin
         op_a = '0;
      end
      if (fwd_valid_ff && fwd_addr_ff == rs2) begin
         op_b = fwd_data_ff;
      end else if (rs2_vld_ff) begin
         op_b = rs2_data_ff;
      end else begin
         op_b = '0;
      end
   end

   // immediates, all signed from bit 31
   assign imm_i = {{20{s1_instr_ff[31]}}, s1_instr_ff[31:20]};
   assign imm_b = {{20{s1_instr_ff[31]}}, s1_instr_ff[7], s1_instr_ff[30:25],
                   s1_instr_ff[11:8], 1'b0};
   assign imm_j = {{12{s1_instr_ff[31]}}, s1_instr_ff[19:12], s1_instr_ff[20],
                   s1_instr_ff[30:21], 1'b0};
   assign imm_u = {s1_instr_ff[31:12], 12'd0};

   assign seq_pc   = pc_ff + PC_STEP;
   assign shamt    = op_b[4:0];
   assign rot_wide = {op_a, op_a} >> shamt;
   assign lt_s     = $signed(op_a) < $signed(op_b);
   assign lt_u     = op_a < op_b;

   // execute
   always_comb begin
      val   = '0;
      npc   = seq_pc;
      wr    = 1'b0;
      redir = 1'b0;
      ill   = 1'b0;
      take  = 1'b0;
      unique case (s1_cmd_ff)
         CMD_REG: begin
            if (f7 == F7_BASE) begin
               wr = 1'b1;
               unique case (f3)
                  F3_ADD:  val = op_a + op_b;
                  F3_SLL:  val = op_a << shamt;
                  F3_SLT:  val = XLEN'(lt_s);
                  F3_SLTU: val = XLEN'(lt_u);
                  F3_XOR:  val = op_a ^ op_b;
                  F3_SRL:  val = op_a >> shamt;
                  F3_OR:   val = op_a | op_b;
                  default: val = op_a & op_b;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               val = op_a - op_b;
               wr  = 1'b1;
            end else if (f7 == F7_ALT && f3 == F3_SRL) begin
               // sra in this block rotates right
               val = rot_wide[XLEN-1:0];
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         CMD_IMM: begin
            wr = 1'b1;
            unique case (f3)
               F3_ADD:  val = op_a + imm_i;
               F3_SLT:  val = XLEN'($signed(op_a) < $signed(imm_i));
               F3_SLTU: val = XLEN'(op_a < imm_i);
               F3_XOR:  val = op_a ^ imm_i;
               F3_OR:   val = op_a | imm_i;
               F3_AND:  val = op_a & imm_i;
               default: begin
                  wr  = 1'b0;
                  ill = 1'b1;
               end
            endcase
         end
         CMD_LUI: begin
            val = imm_u;
            wr  = 1'b1;
         end
         CMD_BRANCH: begin
            unique case (f3)
               F3_BEQ:  take = op_a == op_b;
               F3_BNE:  take = op_a != op_b;
               F3_BLT:  take = lt_s;
               F3_BGE:  take = !lt_s;
               F3_BLTU: take = lt_u;
               F3_BGEU: take = !lt_u;
               default: ill  = 1'b1;
            endcase
            if (take) begin
               npc   = pc_ff + imm_b;
               redir = 1'b1;
            end
         end
         CMD_JAL: begin
            val   = seq_pc;
            wr    = 1'b1;
            npc   = pc_ff + imm_j;
            redir = 1'b1;
         end
         CMD_JALR: begin
            if (f3 == F3_JALR) begin
               // target uses rs1 as read, before this item's write-back
               val   = seq_pc;
               wr    = 1'b1;
               npc   = op_a + imm_i;
               redir = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         default: ill = 1'b1;
      endcase
   end

   // write-back, x0 and illegal items drop the write
   assign rf_we    = s1_adv && wr && !ill && rd != '0;
   assign rf_waddr = rd;
   assign rf_wdata = val;

   always_comb begin
      rsp_in.dest_write = wr && !ill && rd != '0;
      rsp_in.dest_reg   = rsp_in.dest_write ? rd  : '0;
      rsp_in.dest_value = rsp_in.dest_write ? val : '0;
      rsp_in.next_pc    = npc;
      rsp_in.redirected = redir;
      rsp_in.illegal    = ill;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rf_vld_ff    <= '0;
         pc_ff        <= '0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= npc;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rf_we) begin
            fwd_valid_ff        <= 1'b1;
            rf_vld_ff[rf_waddr] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rf_we) begin
         fwd_addr_ff <= rf_waddr;
         fwd_data_ff <= rf_wdata;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.dest_reg   = rsp_ff.dest_reg;
   assign rsp_bus.dest_value = rsp_ff.dest_value;
   assign rsp_bus.dest_write = rsp_ff.dest_write;
   assign rsp_bus.next_pc    = rsp_ff.next_pc;
   assign rsp_bus.redirected = rsp_ff.redirected;
   assign rsp_bus.illegal    = rsp_ff.illegal;

   // checks
   `RVX_ASSERT_NOW(a_no_x0_write, rf_we, rf_waddr != '0, "write-back aimed at x0")
   `RVX_ASSERT_NOW(a_illegal_is_quiet, rsp_valid_ff && rsp_ff.illegal,
      !rsp_ff.dest_write && !rsp_ff.redirected, "illegal item wrote or redirected")
   `RVX_ASSERT_NEXT(a_pc_matches_rsp, s1_adv, rsp_ff.next_pc == pc_ff,
      "pc and reported next pc disagree")

endmodule
